// ----- rtl/core/vdlp_pkg.sv -----
package vdlp_pkg;

  // Field widths fixed by the register map and the timestamp counter
  localparam int TF_W   = 20;
  localparam int FP_W   = 19;
  localparam int TS_W   = 32;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 20;

  // Defaults for the top-level parameters
  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int DEF_TIMEOUT_US   = 300000;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_TIME_CONSTANT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FIXED_PERIOD  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_USE_FIXED     = 2'd2;

  // Register reset values
  localparam logic [TF_W-1:0] TF_RESET = 20'd1000;
  localparam logic [FP_W-1:0] FP_RESET = 19'd50;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [TF_W-1:0] time_constant_us;
    logic [FP_W-1:0] fixed_period_us;
    logic            use_fixed_period;
  } cfg_t;

endpackage

// ----- rtl/core/vdlp_addsub.sv -----
module vdlp_addsub #(
  parameter int W = 52
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);

  // Shared adder/subtractor, reused by every step of the sequencer
  assign sum = sub ? (a - b) : (a + b);

endmodule

// ----- rtl/core/vdlp_core.sv -----
module vdlp_core #(
  parameter int SAMPLE_WIDTH = vdlp_pkg::DEF_SAMPLE_WIDTH,
  parameter int TIMEOUT_US   = vdlp_pkg::DEF_TIMEOUT_US
) (
  input  logic                     clk,
  input  logic                     rst,
  input  vdlp_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_WIDTH-1:0]  sample,
  input  logic [vdlp_pkg::TS_W-1:0] timestamp_us,
  input  logic                     out_free,
  output logic                     out_load,
  output logic [SAMPLE_WIDTH-1:0]  filtered,
  output logic                     passed_through
);
  import vdlp_pkg::*;

  localparam int FIX_MAX = 2**FP_W - 1;
  localparam int DT_MAX  = (TIMEOUT_US > FIX_MAX) ? TIMEOUT_US : FIX_MAX;
  localparam int DTW     = $clog2(DT_MAX + 1);
  localparam int DENW    = ((TF_W > DTW) ? TF_W : DTW) + 1;
  localparam int QW      = SAMPLE_WIDTH + 1;
  localparam int PW      = QW + DTW;
  localparam int AW      = (PW > TS_W + 2) ? PW : TS_W + 2;
  localparam int NMAX    = (QW > DTW) ? QW : DTW;
  localparam int CW      = $clog2(NMAX + 1);
  localparam logic [TS_W-1:0] TIMEOUT = TS_W'(TIMEOUT_US);

  typedef enum logic [2:0] {
    S_IDLE, S_DT, S_DEN, S_DIFF, S_ABS, S_MUL, S_DIV, S_FIN
  } state_t;

  state_t                  state;
  logic [SAMPLE_WIDTH-1:0] x;
  logic [SAMPLE_WIDTH-1:0] y;
  logic [TS_W-1:0]         ts;
  logic [TS_W-1:0]         last_ts;
  logic [DTW-1:0]          dt;
  logic [DENW-1:0]         den;
  logic                    neg;
  logic                    pass;
  logic [QW-1:0]           m;
  logic [AW-1:0]           prod;
  logic [DENW-1:0]         rem;
  logic [QW-1:0]           low;
  logic [CW-1:0]           cnt;

  logic [AW-1:0]           add_a;
  logic [AW-1:0]           add_b;
  logic                    add_sub;
  logic [AW-1:0]           sum;
  logic [SAMPLE_WIDTH-1:0] result;

  vdlp_addsub #(.W(AW)) u_addsub (
    .a   (add_a),
    .b   (add_b),
    .sub (add_sub),
    .sum (sum)
  );

  // Operand select for the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    case (state)
      S_DT: begin
        add_a = AW'(ts);
        add_b = AW'(last_ts);
      end
      S_DEN: begin
        add_a   = AW'(cfg.time_constant_us);
        add_b   = AW'(dt);
        add_sub = 1'b0;
      end
      S_DIFF: begin
        add_a = {{(AW-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
        add_b = {{(AW-SAMPLE_WIDTH){y[SAMPLE_WIDTH-1]}}, y};
      end
      S_ABS: begin
        add_a = {{(AW-SAMPLE_WIDTH){y[SAMPLE_WIDTH-1]}}, y};
        add_b = {{(AW-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
      end
      S_MUL: begin
        // shift-add, multiplier bits MSB first
        add_a   = {prod[AW-2:0], 1'b0};
        add_b   = dt[DTW-1] ? AW'(m) : '0;
        add_sub = 1'b0;
      end
      S_DIV: begin
        // restoring trial subtract
        add_a = AW'({rem, low[QW-1]});
        add_b = AW'(den);
      end
      S_FIN: begin
        add_a   = {{(AW-SAMPLE_WIDTH){y[SAMPLE_WIDTH-1]}}, y};
        add_b   = AW'(low);
        add_sub = neg;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign result = pass ? x : sum[SAMPLE_WIDTH-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      y       <= '0;
      last_ts <= '0;
      pass    <= 1'b0;
      cnt     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= sample;
            ts    <= timestamp_us;
            state <= S_DT;
          end
        end
        S_DT: begin
          last_ts <= ts;
          if (!cfg.use_fixed_period && (sum[TS_W-1:0] > TIMEOUT)) begin
            pass  <= 1'b1;
            state <= S_FIN;
          end else begin
            pass  <= 1'b0;
            dt    <= cfg.use_fixed_period ? DTW'(cfg.fixed_period_us) : sum[DTW-1:0];
            state <= S_DEN;
          end
        end
        S_DEN: begin
          den <= sum[DENW-1:0];
          if (sum[DENW-1:0] == '0) begin
            // no denominator: output holds
            low   <= '0;
            neg   <= 1'b0;
            state <= S_FIN;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          neg   <= sum[AW-1];
          m     <= sum[QW-1:0];
          state <= S_ABS;
        end
        S_ABS: begin
          if (neg) begin
            m <= sum[QW-1:0];
          end
          prod  <= '0;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= sum;
          dt   <= {dt[DTW-2:0], 1'b0};
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(DTW - 1)) begin
            // product done: load divider, top bits as partial remainder
            rem   <= DENW'(sum[PW-1:QW]);
            low   <= sum[QW-1:0];
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          low <= {low[QW-2:0], ~sum[AW-1]};
          rem <= sum[AW-1] ? {rem[DENW-2:0], low[QW-1]} : sum[DENW-1:0];
          cnt <= cnt + CW'(1);
          if (cnt == CW'(QW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            y     <= result;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = (state == S_IDLE);
  assign out_load       = (state == S_FIN) && out_free;
  assign filtered       = result;
  assign passed_through = pass;

endmodule

// ----- rtl/core/variable_dt_lowpass_filter.sv -----
// Channel  Dir  tdata (low bit up)                  tuser
// s_axis   in   sample, timestamp_us, zero pad      -
// m_axis   out  filtered, zero pad                  passed_through
// cfg      in   cfg_we / cfg_index / cfg_data, write only
//
// Each item is finished before the next is accepted. DTW is the dt width
// (19 at defaults). One adder does the dt and gain setup, a shift-add
// multiply of one dt bit per cycle, then a restoring divide of one
// quotient bit per cycle. A timeout pass-through (variable dt only) or a
// zero denominator skips the multiply and divide.
// Synchronous reset clears the filter state and output valid and loads the config reset values.
// The result waits in an output register; a stalled output holds the core.
module variable_dt_lowpass_filter #(
  parameter int SAMPLE_WIDTH = vdlp_pkg::DEF_SAMPLE_WIDTH,
  parameter int TIMEOUT_US   = vdlp_pkg::DEF_TIMEOUT_US
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample, timestamp_us
  input  logic [((SAMPLE_WIDTH+vdlp_pkg::TS_W+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // filtered
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  // passed_through
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic [vdlp_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [vdlp_pkg::CFG_DW-1:0]       cfg_data
);
  import vdlp_pkg::*;

  localparam int OUT_TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  cfg_t                    cfg;
  logic                    out_free;
  logic                    out_load;
  logic [SAMPLE_WIDTH-1:0] filtered;
  logic                    passed_through;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_constant_us <= TF_RESET;
      cfg.fixed_period_us  <= FP_RESET;
      cfg.use_fixed_period <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_CONSTANT: cfg.time_constant_us <= cfg_data[TF_W-1:0];
        REG_FIXED_PERIOD:  cfg.fixed_period_us  <= cfg_data[FP_W-1:0];
        REG_USE_FIXED:     cfg.use_fixed_period <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vdlp_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TIMEOUT_US   (TIMEOUT_US)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .sample         (s_tdata[SAMPLE_WIDTH-1:0]),
    .timestamp_us   (s_tdata[SAMPLE_WIDTH+TS_W-1:SAMPLE_WIDTH]),
    .out_free       (out_free),
    .out_load       (out_load),
    .filtered       (filtered),
    .passed_through (passed_through)
  );

  assign out_free = !m_tvalid || m_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_TDW'(filtered);
        m_tuser  <= passed_through;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/vdlp_checker.sv -----
module vdlp_checker #(
  parameter int OUT_TDW = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_TDW-1:0] m_tdata,
  input logic [0:0]         m_tuser
);

  // Output is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after a request");

  // A new result only comes out of the busy sequence
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind variable_dt_lowpass_filter vdlp_checker #(.OUT_TDW(OUT_TDW)) u_vdlp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
